@@ design/bbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg - shared types of the clipped 3x3 box blur
// pixel and line store words, border clip flags and datapath stage controls
// ----------------------------------------------------------------------------
package bbc_pkg;

	// register indexes of the configuration port
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// input item kinds
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// one rgb pixel, eight bits per channel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// one line store word: the two rows above the incoming row, same column
	typedef struct packed {
		rgb_t upper;
		rgb_t middle;
	} line_pair_t;

	// which neighbors of the output pixel lie inside the frame
	typedef struct packed {
		logic has_top;
		logic has_bottom;
		logic has_left;
		logic has_right;
		logic last;
	} clip_flags_t;

	// stage advance strobes from the control into the datapath
	typedef struct packed {
		logic shift_en;
		logic sum_en;
		logic out_en;
	} dp_ctrl_t;

endpackage
`default_nettype wire

@@ design/bbc_line_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_line_ram - line store memory
// one write port and one read port, registered read data, read-first
// ----------------------------------------------------------------------------
module bbc_line_ram #(
	parameter int DEPTH = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire bbc_pkg::line_pair_t                  wdata,
	input  wire logic                                 re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output bbc_pkg::line_pair_t                       rdata
);

	bbc_pkg::line_pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/bbc_window.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_window - 3x3 window, clipped sums and rounded mean
// window shift (s2), masked channel sums (s3), mean and result register (s4)
// ----------------------------------------------------------------------------
module bbc_window (
	input  wire logic                 clk,
	input  wire bbc_pkg::dp_ctrl_t    ctrl,
	input  wire bbc_pkg::line_pair_t  col_pair,
	input  wire bbc_pkg::rgb_t        col_lower,
	input  wire bbc_pkg::clip_flags_t flags_in,
	output bbc_pkg::rgb_t             result,
	output logic                      result_last
);

	localparam int SUM_W = 12;
	// floor(y/3) = (y*2731)>>13 and floor(y/9) = (y*3641)>>15 for y < 4096
	localparam logic [SUM_W-1:0] RECIP3 = 12'd2731;
	localparam logic [SUM_W-1:0] RECIP9 = 12'd3641;

	// window[column][row], column 0 oldest, row 0 top
	bbc_pkg::rgb_t       win_s2 [3][3];
	bbc_pkg::clip_flags_t flags_s2;

	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;
	logic [1:0]       rows_n;
	logic [1:0]       cols_n;
	logic [3:0]       count_n;

	logic [SUM_W-1:0] sum_r_s3;
	logic [SUM_W-1:0] sum_g_s3;
	logic [SUM_W-1:0] sum_b_s3;
	logic [3:0]       count_s3;
	logic             last_s3;

	bbc_pkg::rgb_t    res_s4;
	logic             last_s4;

	// (2*sum + n) / (2*n) for n in 1, 2, 3, 4, 6, 9
	function automatic logic [7:0] mean_round(input logic [SUM_W-1:0] s, input logic [3:0] n);
		logic [SUM_W:0]     x;
		logic [SUM_W-1:0]   y;
		logic [2*SUM_W-1:0] p;
		logic [7:0]         q;
		x = {s, 1'b0} + (SUM_W+1)'(n);
		y = '0;
		p = '0;
		q = '0;
		case (n)
			4'd1: q = 8'(x >> 1);
			4'd2: q = 8'(x >> 2);
			4'd4: q = 8'(x >> 3);
			4'd3: begin
				y = SUM_W'(x >> 1);
				p = {{SUM_W{1'b0}}, y} * {{SUM_W{1'b0}}, RECIP3};
				q = 8'(p >> 13);
			end
			4'd6: begin
				y = SUM_W'(x >> 2);
				p = {{SUM_W{1'b0}}, y} * {{SUM_W{1'b0}}, RECIP3};
				q = 8'(p >> 13);
			end
			4'd9: begin
				y = SUM_W'(x >> 1);
				p = {{SUM_W{1'b0}}, y} * {{SUM_W{1'b0}}, RECIP9};
				q = 8'(p >> 15);
			end
			default: q = '0;
		endcase
		return q;
	endfunction

	// window shift, one column per item
	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			win_s2[0]    <= win_s2[1];
			win_s2[1]    <= win_s2[2];
			win_s2[2][0] <= col_pair.upper;
			win_s2[2][1] <= col_pair.middle;
			win_s2[2][2] <= col_lower;
			flags_s2     <= flags_in;
		end
	end

	always_comb begin
		row_ok = {flags_s2.has_bottom, 1'b1, flags_s2.has_top};
		col_ok = {flags_s2.has_right, 1'b1, flags_s2.has_left};
		sum_r  = '0;
		sum_g  = '0;
		sum_b  = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_r = sum_r + SUM_W'(win_s2[c][r].red);
					sum_g = sum_g + SUM_W'(win_s2[c][r].green);
					sum_b = sum_b + SUM_W'(win_s2[c][r].blue);
				end
			end
		end
		rows_n  = 2'd1 + 2'(flags_s2.has_top) + 2'(flags_s2.has_bottom);
		cols_n  = 2'd1 + 2'(flags_s2.has_left) + 2'(flags_s2.has_right);
		count_n = {2'b00, rows_n} * {2'b00, cols_n};
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum_en) begin
			sum_r_s3 <= sum_r;
			sum_g_s3 <= sum_g;
			sum_b_s3 <= sum_b;
			count_s3 <= count_n;
			last_s3  <= flags_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_en) begin
			res_s4.red   <= mean_round(sum_r_s3, count_s3);
			res_s4.green <= mean_round(sum_g_s3, count_s3);
			res_s4.blue  <= mean_round(sum_b_s3, count_s3);
			last_s4      <= last_s3;
		end
	end

	assign result      = res_s4;
	assign result_last = last_s4;

endmodule
`default_nettype wire

@@ design/box_blur_3x3_clipped.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_clipped - streaming 3x3 box blur on rgb pixels
// raster-order pixels in, mean of the clipped 3x3 neighborhood out, rounded
// half up; results trail the input by one row plus one pixel, flush items
// drain the tail of the frame and the final result carries frame_last
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | mode, in_red, in_green, in_blue
//  out     | out_valid/out_stall | out_red, out_green, out_blue, frame_last
//  cfg     | cfg_we              | cfg_idx (0 width, 1 height), cfg_data
//
//  one item per cycle while in_stall is low: the line store does one read and one write per cycle
//  a result enters the output register once the item that
//  completes its neighborhood has passed line read, window shift, sums and mean
//  reset clears counters and valid bits; line stores need no clearing
//  a one-row frame stalls the input in the cycle after its last pixel
//  otherwise in_stall follows out_stall back through the stages s4, s3, s2 and s1
//
module box_blur_3x3_clipped #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [12:0] cfg_data,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_blue,
	// result items
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic             frame_last
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam logic [10:0] FW_RESET = 11'd1024;
	localparam logic [12:0] FH_RESET = 13'd1024;

	// configuration
	logic [10:0]   frame_width_q;
	logic [12:0]   frame_height_q;
	logic [CW-1:0] wm1;              // effective width minus one
	logic [RW-1:0] hm1;              // effective height minus one

	// frame position
	logic [CW-1:0] in_col_q;         // also the read column while draining
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic          draining_q;
	logic          preroll_q;        // one-row frame: extra column pending

	// item decode
	logic          accept;
	logic          real_px;
	logic          drain_px;
	logic          inject;
	logic          s1_load;
	logic          in_last;
	logic          out_last;
	logic          emit_real;
	logic [CW-1:0] col_step;
	bbc_pkg::clip_flags_t flags_in;

	// stage flow
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic out_free;
	logic s3_free;
	logic s3_go;
	logic s2_free;
	logic s2_go;
	logic s1_free;
	logic s1_go;

	// stage 1 payload
	logic                 emit_s1;
	logic                 wr_s1;
	logic [CW-1:0]        col_s1;
	bbc_pkg::rgb_t        pix_s1;
	bbc_pkg::clip_flags_t flags_s1;
	logic                 fwd_hit_s1;
	bbc_pkg::line_pair_t  fwd_pair_s1;

	// line store
	logic                 ram_we;
	bbc_pkg::line_pair_t  ram_wdata;
	bbc_pkg::line_pair_t  rd_pair_s1;
	bbc_pkg::line_pair_t  rd_fwd;

	bbc_pkg::dp_ctrl_t    dp_ctrl;
	bbc_pkg::rgb_t        res_px;

	// ---------------------------------------------------------------------
	// effective frame size: zero acts as one, above the maximum clamps
	// ---------------------------------------------------------------------
	always_comb begin
		if (frame_width_q == '0) begin
			wm1 = '0;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(frame_width_q - 11'd1);
		end
		if (frame_height_q == '0) begin
			hm1 = '0;
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			hm1 = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = RW'(frame_height_q - 13'd1);
		end
	end

	// ---------------------------------------------------------------------
	// item decode
	// ---------------------------------------------------------------------
	assign accept   = in_valid && !in_stall;
	// pixels during draining and flushes outside it are taken and dropped
	assign real_px  = accept && (mode == bbc_pkg::MODE_PIXEL) && !draining_q;
	assign drain_px = accept && (mode == bbc_pkg::MODE_FLUSH) && draining_q;
	assign inject   = preroll_q && s1_free;
	assign s1_load  = real_px || drain_px || inject;

	assign in_last  = (in_row_q == hm1) && (in_col_q == wm1);
	assign out_last = (out_row_q == hm1) && (out_col_q == wm1);
	// results start once one row plus one pixel is in
	assign emit_real = (in_row_q > RW'(1)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign col_step  = (in_col_q == wm1) ? '0 : in_col_q + CW'(1);

	// clip flags of the output pixel this item produces
	always_comb begin
		flags_in.has_top    = (out_row_q != '0);
		flags_in.has_bottom = (out_row_q != hm1);
		flags_in.has_left   = (out_col_q != '0);
		flags_in.has_right  = (out_col_q != wm1);
		flags_in.last       = drain_px && out_last;
	end

	// ---------------------------------------------------------------------
	// configuration and frame counters
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
			in_col_q       <= '0;
			in_row_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
			draining_q     <= 1'b0;
			preroll_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bbc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[10:0];
				bbc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
			endcase
			// any write restarts the frame
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			draining_q <= 1'b0;
			preroll_q  <= 1'b0;
		end else begin
			if (real_px) begin
				if (in_last) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					draining_q <= 1'b1;
					preroll_q  <= (hm1 == '0);
				end else if (in_col_q == wm1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit_real) begin
					if (out_col_q == wm1) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
			if (drain_px) begin
				if (out_last) begin
					out_col_q  <= '0;
					out_row_q  <= '0;
					in_col_q   <= '0;
					draining_q <= 1'b0;
				end else begin
					in_col_q <= col_step;
					if (out_col_q == wm1) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
			if (inject) begin
				preroll_q <= 1'b0;
				in_col_q  <= col_step;
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage flow: each stage fills whenever the one after it can move
	// only items that produce a result go past the window shift
	// ---------------------------------------------------------------------
	assign out_free = !valid_s4 || !out_stall;
	assign s3_free  = !valid_s3 || out_free;
	assign s3_go    = valid_s3 && out_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s2_go    = valid_s2 && s3_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s1_go    = valid_s1 && s2_free;

	assign in_stall = !s1_free || preroll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				valid_s2 <= emit_s1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (s2_go) begin
				valid_s3 <= 1'b1;
			end else if (s3_go) begin
				valid_s3 <= 1'b0;
			end
			if (s3_go) begin
				valid_s4 <= 1'b1;
			end else if (out_free) begin
				valid_s4 <= 1'b0;
			end
		end
	end

	// stage 1 payload; the line store read is issued on the same edge
	always_ff @(posedge clk) begin
		if (s1_load) begin
			emit_s1     <= real_px ? emit_real : drain_px;
			wr_s1       <= real_px;
			col_s1      <= in_col_q;
			pix_s1      <= {in_red, in_green, in_blue};
			flags_s1    <= flags_in;
			// a write to the column being read on this edge is not seen by
			// the read-first memory, keep a copy of it
			fwd_hit_s1  <= ram_we && (col_s1 == in_col_q);
			fwd_pair_s1 <= ram_wdata;
		end
	end

	// ---------------------------------------------------------------------
	// line store: column j holds rows i-2 and i-1 for the incoming row i
	// ---------------------------------------------------------------------
	assign rd_fwd          = fwd_hit_s1 ? fwd_pair_s1 : rd_pair_s1;
	assign ram_we          = s1_go && wr_s1;
	assign ram_wdata.upper  = rd_fwd.middle;
	assign ram_wdata.middle = pix_s1;

	bbc_line_ram #(
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (ram_wdata),
		.re    (s1_load),
		.raddr (in_col_q),
		.rdata (rd_pair_s1)
	);

	// ---------------------------------------------------------------------
	// window, sums and mean
	// ---------------------------------------------------------------------
	always_comb begin
		dp_ctrl.shift_en = s1_go;
		dp_ctrl.sum_en   = s2_go;
		dp_ctrl.out_en   = s3_go;
	end

	bbc_window u_window (
		.clk         (clk),
		.ctrl        (dp_ctrl),
		.col_pair    (rd_fwd),
		.col_lower   (pix_s1),
		.flags_in    (flags_s1),
		.result      (res_px),
		.result_last (frame_last)
	);

	assign out_valid = valid_s4;
	assign out_red   = res_px.red;
	assign out_green = res_px.green;
	assign out_blue  = res_px.blue;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_preroll_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		preroll_q |-> draining_q)
		else $error("extra column pending outside draining");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		real_px && in_last && !cfg_we |=> draining_q)
		else $error("last pixel of frame did not start draining");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		drain_px && out_last && !cfg_we |=> !draining_q && (in_col_q == '0))
		else $error("final result did not end draining");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_col_q <= wm1) && (out_col_q <= wm1))
		else $error("column counter beyond frame width");

endmodule
`default_nettype wire
